FILE: sv/pixel_scene_classifier_defines.svh
// assertion macros used by the pixel scene classifier rtl
`ifndef PIXEL_SCENE_CLASSIFIER_DEFINES_SVH
`define PIXEL_SCENE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge out of reset
`define PSC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("psc assertion failed");

// consequent holds in the cycle after the antecedent
`define PSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psc assertion failed");

`else

`define PSC_ASSERT(name, clk, rst_n, prop)
`define PSC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/psc_pkg.sv
// types and constants of the pixel scene classifier
package psc_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 25;
  localparam int CTR_W     = 23;
  localparam int CLASS_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // gray = sum/3, so gray < 70 is sum < 210 and gray > 190 is sum >= 573
  localparam logic [9:0] DARK_SUM_LIM   = 10'd210;
  localparam logic [9:0] BRIGHT_SUM_MIN = 10'd573;

  localparam logic [PIX_W-1:0] SKIN_R_MIN    = 8'd55;
  localparam logic [PIX_W-1:0] SKIN_G_MIN    = 8'd35;
  localparam logic [PIX_W-1:0] SKIN_B_MIN    = 8'd25;
  localparam logic [PIX_W-1:0] SKIN_DIFF_LIM = 8'd55;

  // percentages of the frame area (centre dark: of the centre window), compared by cross multiplication
  localparam int PCT_SCALE        = 100;
  localparam int SKIN_PCT         = 18;
  localparam int DARK_OBJ_PCT     = 3;
  localparam int BRIGHT_PCT       = 45;
  localparam int BRIGHT_DARK_PCT  = 5;
  localparam int CENTRE_DARK_PCT  = 8;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SKIN     = 3'd0,
    CLS_DARK_OBJ = 3'd1,
    CLS_BRIGHT   = 3'd2,
    CLS_CENTRE   = 3'd3,
    CLS_UNKNOWN  = 3'd4
  } psc_class_e;

  typedef struct packed {
    logic [CNT_W-1:0] dark;
    logic [CNT_W-1:0] bright;
    logic [CNT_W-1:0] skin;
    logic [CTR_W-1:0] centre;
    logic [CTR_W-1:0] centre_dark;
  } psc_counts_t;

endpackage

FILE: sv/pixel_scene_classifier.sv
// top level of the pixel scene classifier: config registers and pipeline
//
// pixels enter on the input channel (valid/ready) in raster order, one item
// per pixel; the block tracks column and row itself from frame_width and
// frame_height (0 acts as 1, values above MAX_DIM act as MAX_DIM).
// every pixel updates running counts; only the last pixel of a frame makes
// a result item: the scene class and the dark, bright, skin and centre dark
// totals. the frame state then clears for the next frame.
// throughput is one pixel per cycle while in_ready_o is high; the pipeline is
// pixel register, accumulate, area multiply, decision/result register, and a
// frame's result passes through them in that order before it is offered.
// the result register parts the two sides: pixels keep flowing while a
// result waits; only when the result register and the two stages before it
// are all full does the last pixel of the next frame hold the input.
// reset (rst_ni low, asynchronous) empties the pipeline, zeroes position
// and counts and loads frame_width 640, frame_height 480.
// config writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once; the user
// must make them while no item is in flight: the block does not enforce it.
module pixel_scene_classifier #(
  parameter int MAX_DIM = psc_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psc_pkg::PIX_W-1:0]     red_i,
  input  logic [psc_pkg::PIX_W-1:0]     green_i,
  input  logic [psc_pkg::PIX_W-1:0]     blue_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psc_pkg::CLASS_W-1:0]   scene_class_o,
  output logic [psc_pkg::CNT_W-1:0]     dark_total_o,
  output logic [psc_pkg::CNT_W-1:0]     bright_total_o,
  output logic [psc_pkg::CNT_W-1:0]     skin_total_o,
  output logic [psc_pkg::CTR_W-1:0]     centre_dark_total_o
);
  import psc_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = CW + 1;
  localparam int XW = (DW > CFG_W) ? DW : CFG_W;

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [XW-1:0]    width_x, height_x;
  logic [DW-1:0]    width, height;

  logic          fin_valid, fin_ready;
  psc_counts_t   fin_cnt, out_cnt;
  logic [CW-1:0] fin_left, fin_right, fin_top, fin_bottom;
  logic [DW-1:0] fin_width, fin_height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the dimensions into 1..MAX_DIM
  always_comb begin
    width_x  = XW'(frame_width_q);
    height_x = XW'(frame_height_q);
    if (width_x == '0)                width_x = XW'(1);
    else if (width_x > XW'(MAX_DIM))  width_x = XW'(MAX_DIM);
    if (height_x == '0)               height_x = XW'(1);
    else if (height_x > XW'(MAX_DIM)) height_x = XW'(MAX_DIM);
    width  = width_x[DW-1:0];
    height = height_x[DW-1:0];
  end

  psc_accum #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW),
    .DW      (DW)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .width_i      (width),
    .height_i     (height),
    .fin_valid_o  (fin_valid),
    .fin_ready_i  (fin_ready),
    .fin_cnt_o    (fin_cnt),
    .fin_left_o   (fin_left),
    .fin_right_o  (fin_right),
    .fin_top_o    (fin_top),
    .fin_bottom_o (fin_bottom),
    .fin_width_o  (fin_width),
    .fin_height_o (fin_height)
  );

  psc_classify #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW),
    .DW      (DW)
  ) u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_valid_i   (fin_valid),
    .fin_ready_o   (fin_ready),
    .fin_cnt_i     (fin_cnt),
    .fin_left_i    (fin_left),
    .fin_right_i   (fin_right),
    .fin_top_i     (fin_top),
    .fin_bottom_i  (fin_bottom),
    .fin_width_i   (fin_width),
    .fin_height_i  (fin_height),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scene_class_o (scene_class_o),
    .out_cnt_o     (out_cnt)
  );

  assign dark_total_o        = out_cnt.dark;
  assign bright_total_o      = out_cnt.bright;
  assign skin_total_o        = out_cnt.skin;
  assign centre_dark_total_o = out_cnt.centre_dark;

endmodule

FILE: sv/psc_accum.sv
// pixel register, per-pixel tests, raster position and frame accumulators
`include "pixel_scene_classifier_defines.svh"

module psc_accum #(
  parameter int MAX_DIM = psc_pkg::MAX_DIM_DEF,
  parameter int CW      = $clog2(MAX_DIM),
  parameter int DW      = CW + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [psc_pkg::PIX_W-1:0] red_i,
  input  logic [psc_pkg::PIX_W-1:0] green_i,
  input  logic [psc_pkg::PIX_W-1:0] blue_i,
  input  logic [DW-1:0]            width_i,
  input  logic [DW-1:0]            height_i,
  output logic                     fin_valid_o,
  input  logic                     fin_ready_i,
  output psc_pkg::psc_counts_t     fin_cnt_o,
  output logic [CW-1:0]            fin_left_o,
  output logic [CW-1:0]            fin_right_o,
  output logic [CW-1:0]            fin_top_o,
  output logic [CW-1:0]            fin_bottom_o,
  output logic [DW-1:0]            fin_width_o,
  output logic [DW-1:0]            fin_height_o
);
  import psc_pkg::*;

  logic             pix_vld_q;
  logic [PIX_W-1:0] red_q, green_q, blue_q;

  logic [CW-1:0]    col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] dark_q, dark_d, bright_q, bright_d, skin_q, skin_d;
  logic [CTR_W-1:0] ccount_q, ccount_d, cdark_q, cdark_d;
  logic [CW-1:0]    left_q, left_d, right_q, right_d, top_q, top_d, bottom_q, bottom_d;

  logic             fin_vld_q;
  psc_counts_t      fin_cnt_q;
  logic [CW-1:0]    fin_left_q, fin_right_q, fin_top_q, fin_bottom_q;
  logic [DW-1:0]    fin_w_q, fin_h_q;

  logic [9:0]       sum;
  logic             is_dark, is_bright, is_skin, in_centre;
  logic [DW-1:0]    x_ext, y_ext, x_inc, y_inc, quarter_w, quarter_h;
  logic             row_end, frame_end, fin_free, pix_go;

  always_comb begin
    sum       = {2'b00, red_q} + {2'b00, green_q} + {2'b00, blue_q};
    is_dark   = sum < DARK_SUM_LIM;
    is_bright = !is_dark && (sum >= BRIGHT_SUM_MIN);
    is_skin   = (red_q > SKIN_R_MIN) && (green_q > SKIN_G_MIN) && (blue_q > SKIN_B_MIN) &&
                (red_q >= green_q) && ((red_q - green_q) < SKIN_DIFF_LIM);

    x_ext     = {1'b0, col_q};
    y_ext     = {1'b0, row_q};
    x_inc     = x_ext + DW'(1);
    y_inc     = y_ext + DW'(1);
    quarter_w = width_i >> 2;
    quarter_h = height_i >> 2;
    // window spans w/2 columns from w/4, h/2 rows from h/4
    in_centre = (x_ext >= quarter_w) && (x_ext < quarter_w + (width_i >> 1)) &&
                (y_ext >= quarter_h) && (y_ext < quarter_h + (height_i >> 1));
    row_end   = x_inc >= width_i;
    frame_end = row_end && (y_inc >= height_i);
  end

  assign fin_free   = !fin_vld_q || fin_ready_i;
  assign pix_go     = pix_vld_q && (!frame_end || fin_free);
  assign in_ready_o = !pix_vld_q || pix_go;

  always_comb begin
    dark_d   = dark_q;
    bright_d = bright_q;
    skin_d   = skin_q;
    ccount_d = ccount_q;
    cdark_d  = cdark_q;
    left_d   = left_q;
    right_d  = right_q;
    top_d    = top_q;
    bottom_d = bottom_q;

    if (is_dark) begin
      // first dark pixel of the frame seeds the box
      if (dark_q == '0 || col_q < left_q)   left_d   = col_q;
      if (dark_q == '0 || col_q > right_q)  right_d  = col_q;
      if (dark_q == '0 || row_q < top_q)    top_d    = row_q;
      if (dark_q == '0 || row_q > bottom_q) bottom_d = row_q;
      if (!(&dark_q)) dark_d = dark_q + CNT_W'(1);
    end else if (is_bright) begin
      if (!(&bright_q)) bright_d = bright_q + CNT_W'(1);
    end
    if (is_skin && !(&skin_q)) skin_d = skin_q + CNT_W'(1);
    if (in_centre) begin
      if (!(&ccount_q)) ccount_d = ccount_q + CTR_W'(1);
      if (is_dark && !(&cdark_q)) cdark_d = cdark_q + CTR_W'(1);
    end

    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : y_inc[CW-1:0];
    end else begin
      col_d = x_inc[CW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      pix_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      dark_q   <= '0;
      bright_q <= '0;
      skin_q   <= '0;
      ccount_q <= '0;
      cdark_q  <= '0;
    end else if (pix_go) begin
      col_q <= col_d;
      row_q <= row_d;
      if (frame_end) begin
        dark_q   <= '0;
        bright_q <= '0;
        skin_q   <= '0;
        ccount_q <= '0;
        cdark_q  <= '0;
      end else begin
        dark_q   <= dark_d;
        bright_q <= bright_d;
        skin_q   <= skin_d;
        ccount_q <= ccount_d;
        cdark_q  <= cdark_d;
      end
    end
  end

  // box is only read while the dark count is nonzero
  always_ff @(posedge clk_i) begin
    if (pix_go) begin
      left_q   <= left_d;
      right_q  <= right_d;
      top_q    <= top_d;
      bottom_q <= bottom_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (fin_free) begin
      fin_vld_q <= pix_go && frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_go && frame_end) begin
      fin_cnt_q.dark        <= dark_d;
      fin_cnt_q.bright      <= bright_d;
      fin_cnt_q.skin        <= skin_d;
      fin_cnt_q.centre      <= ccount_d;
      fin_cnt_q.centre_dark <= cdark_d;
      fin_left_q            <= left_d;
      fin_right_q           <= right_d;
      fin_top_q             <= top_d;
      fin_bottom_q          <= bottom_d;
      fin_w_q               <= width_i;
      fin_h_q               <= height_i;
    end
  end

  assign fin_valid_o  = fin_vld_q;
  assign fin_cnt_o    = fin_cnt_q;
  assign fin_left_o   = fin_left_q;
  assign fin_right_o  = fin_right_q;
  assign fin_top_o    = fin_top_q;
  assign fin_bottom_o = fin_bottom_q;
  assign fin_width_o  = fin_w_q;
  assign fin_height_o = fin_h_q;

  `PSC_ASSERT_NEXT(a_frame_clears, clk_i, rst_ni, pix_go && frame_end, col_q == '0 && row_q == '0 && dark_q == '0 && fin_vld_q)
  `PSC_ASSERT(a_cdark_le_dark, clk_i, rst_ni, CNT_W'(cdark_q) <= dark_q)
  `PSC_ASSERT(a_cdark_le_centre, clk_i, rst_ni, cdark_q <= ccount_q)
  `PSC_ASSERT_NEXT(a_fin_holds, clk_i, rst_ni, fin_vld_q && !fin_ready_i, fin_vld_q && $stable(fin_cnt_q))

endmodule

FILE: sv/psc_classify.sv
// frame area product, box aspect and priority scene decision with result register
module psc_classify #(
  parameter int MAX_DIM = psc_pkg::MAX_DIM_DEF,
  parameter int CW      = $clog2(MAX_DIM),
  parameter int DW      = CW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fin_valid_i,
  output logic                        fin_ready_o,
  input  psc_pkg::psc_counts_t        fin_cnt_i,
  input  logic [CW-1:0]               fin_left_i,
  input  logic [CW-1:0]               fin_right_i,
  input  logic [CW-1:0]               fin_top_i,
  input  logic [CW-1:0]               fin_bottom_i,
  input  logic [DW-1:0]               fin_width_i,
  input  logic [DW-1:0]               fin_height_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [psc_pkg::CLASS_W-1:0] scene_class_o,
  output psc_pkg::psc_counts_t        out_cnt_o
);
  import psc_pkg::*;

  localparam int PW   = 2 * DW;
  localparam int CMPW = (PW + 7 > 33) ? PW + 7 : 33;

  logic          s2_vld_q;
  logic [PW-1:0] tot_q;
  psc_counts_t   cnt2_q;
  logic          tall_q, tall_d;

  logic          out_vld_q;
  psc_class_e    class_q, class_d;
  psc_counts_t   cnt_out_q;

  logic          out_load, s2_load;
  logic [CW-1:0] span_w, span_h, span_max, span_min;

  logic [CMPW-1:0] tot, dark_x, bright_x, skin_x, cdark_x, centre_x;
  logic            c_skin, c_dark, c_bright, c_centre;

  assign out_load    = !out_vld_q || out_ready_i;
  assign s2_load     = !s2_vld_q || out_load;
  assign fin_ready_o = s2_load;

  // box spans count as zero without any dark pixel
  always_comb begin
    span_w = '0;
    span_h = '0;
    if (fin_cnt_i.dark != '0) begin
      if (fin_right_i > fin_left_i)  span_w = fin_right_i - fin_left_i;
      if (fin_bottom_i > fin_top_i)  span_h = fin_bottom_i - fin_top_i;
    end
    span_max = (span_w > span_h) ? span_w : span_h;
    span_min = (span_w > span_h) ? span_h : span_w;
    tall_d   = (span_w != '0) && (span_h != '0) &&
               ({1'b0, span_max} >= {span_min, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_load) begin
      s2_vld_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && fin_valid_i) begin
      tot_q  <= PW'(fin_width_i) * PW'(fin_height_i);
      cnt2_q <= fin_cnt_i;
      tall_q <= tall_d;
    end
  end

  always_comb begin
    tot      = CMPW'(tot_q);
    dark_x   = CMPW'(cnt2_q.dark) * CMPW'(PCT_SCALE);
    bright_x = CMPW'(cnt2_q.bright) * CMPW'(PCT_SCALE);
    skin_x   = CMPW'(cnt2_q.skin) * CMPW'(PCT_SCALE);
    cdark_x  = CMPW'(cnt2_q.centre_dark) * CMPW'(PCT_SCALE);
    centre_x = CMPW'(cnt2_q.centre) * CMPW'(CENTRE_DARK_PCT);

    c_skin   = skin_x > CMPW'(SKIN_PCT) * tot;
    c_dark   = (dark_x > CMPW'(DARK_OBJ_PCT) * tot) && tall_q;
    c_bright = (bright_x > CMPW'(BRIGHT_PCT) * tot) &&
               (dark_x < CMPW'(BRIGHT_DARK_PCT) * tot);
    c_centre = (cnt2_q.centre != '0) && (cdark_x > centre_x);

    priority if (c_skin)   class_d = CLS_SKIN;
    else if (c_dark)       class_d = CLS_DARK_OBJ;
    else if (c_bright)     class_d = CLS_BRIGHT;
    else if (c_centre)     class_d = CLS_CENTRE;
    else                   class_d = CLS_UNKNOWN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s2_vld_q) begin
      class_q   <= class_d;
      cnt_out_q <= cnt2_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign scene_class_o = class_q;
  assign out_cnt_o     = cnt_out_q;

endmodule
